FILE: design/i2c_master_transaction_sequencer_defines.svh
// ----------------------------------------------------------------------------
// i2c master transaction sequencer assertion macros
// concurrent assertion helpers used by the sequencer controller (i2cms_ctrl)
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH

// property that must hold on every clock edge outside reset
`define I2CMS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("i2cms assertion failed");

// antecedent implies consequent on the following clock edge
`define I2CMS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("i2cms assertion failed");

`endif

FILE: design/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// types and constants shared by the i2c master transaction sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // buffer geometry
    localparam int BUFFER_DEPTH = 32;
    localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
    localparam logic [7:0] DEPTH_LEN = 8'(BUFFER_DEPTH);
    localparam logic [5:0] DEPTH_IDX = 6'(BUFFER_DEPTH);

    // item kinds on the input channel
    typedef enum logic [1:0] {
        CMD_LOAD_BYTE  = 2'd0,
        CMD_START_XFER = 2'd1,
        CMD_BUS_EVENT  = 2'd2,
        CMD_READ_BYTE  = 2'd3
    } item_cmd_t;

    // commands for the byte-level bus core
    typedef enum logic [2:0] {
        BUS_NONE        = 3'd0,
        BUS_START_WRITE = 3'd1,
        BUS_WRITE       = 3'd2,
        BUS_READ        = 3'd3,
        BUS_STOP        = 3'd4,
        BUS_START       = 3'd5
    } bus_cmd_t;

    // completion status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LONG  = 3'd1,
        ST_ADDR_NACK = 3'd2,
        ST_DATA_NACK = 3'd3,
        ST_OTHER     = 3'd4
    } status_t;

    typedef struct packed {
        item_cmd_t  command;
        logic [4:0] buffer_slot;
        logic [7:0] byte_value;
        logic [6:0] target_address;
        logic       read_not_write;
        logic [7:0] transfer_length;
        logic       end_with_stop;
        logic       arbitration_lost;
        logic       ack_missing;
        logic [7:0] received_byte;
    } in_item_t;

    typedef struct packed {
        bus_cmd_t   bus_command;
        logic [7:0] bus_tx_byte;
        logic       transfer_done;
        status_t    done_status;
        logic [5:0] bytes_moved;
        logic [7:0] buffer_byte;
        logic       busy_res;
    } out_item_t;

    // buffer access request from the controller
    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [BUF_AW-1:0] raddr;
    } buf_req_t;

endpackage

FILE: design/i2cms_buffer.sv
// ----------------------------------------------------------------------------
// i2cms_buffer
// transfer byte buffer: one write port, one asynchronous read port
// ----------------------------------------------------------------------------
module i2cms_buffer (
    input  logic                aclk,
    input  i2cms_pkg::buf_req_t req,
    output logic [7:0]          rdata
);

    logic [7:0] mem_reg [i2cms_pkg::BUFFER_DEPTH];

    // write port, contents undefined until written
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_reg[req.waddr] <= req.wdata;
        end
    end

    // read port
    assign rdata = mem_reg[req.raddr];

endmodule

FILE: design/i2cms_ctrl.sv
// ----------------------------------------------------------------------------
// i2cms_ctrl
// transfer state and next bus command for one item per cycle while en is high
// ----------------------------------------------------------------------------
`include "i2c_master_transaction_sequencer_defines.svh"

module i2cms_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  i2cms_pkg::in_item_t  item,
    input  logic [7:0]           buf_rdata,
    output i2cms_pkg::buf_req_t  buf_req,
    output i2cms_pkg::out_item_t result
);

    typedef enum logic [1:0] {
        PH_READY = 2'd0,
        PH_WRITE = 2'd1,
        PH_READ  = 2'd2
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                stop_at_end_reg, stop_at_end_next;
    logic                rs_pending_reg, rs_pending_next;
    logic                addr_phase_reg, addr_phase_next;
    logic [5:0]          byte_index_reg, byte_index_next;
    logic [5:0]          byte_count_reg, byte_count_next;
    i2cms_pkg::status_t  fault_code_reg, fault_code_next;

    logic slot_ok;
    logic moved_zero;

    assign slot_ok = 8'(item.buffer_slot) < i2cms_pkg::DEPTH_LEN;

    // next state and result for the current item
    always_comb begin
        phase_next       = phase_reg;
        stop_at_end_next = stop_at_end_reg;
        rs_pending_next  = rs_pending_reg;
        addr_phase_next  = addr_phase_reg;
        byte_index_next  = byte_index_reg;
        byte_count_next  = byte_count_reg;
        fault_code_next  = fault_code_reg;
        moved_zero       = 1'b0;

        buf_req.we    = 1'b0;
        buf_req.waddr = item.buffer_slot;
        buf_req.wdata = item.byte_value;
        buf_req.raddr = (item.command == i2cms_pkg::CMD_READ_BYTE) ?
                        item.buffer_slot : byte_index_reg[i2cms_pkg::BUF_AW-1:0];

        result.bus_command   = i2cms_pkg::BUS_NONE;
        result.bus_tx_byte   = 8'd0;
        result.transfer_done = 1'b0;
        result.done_status   = i2cms_pkg::ST_OK;
        result.buffer_byte   = 8'd0;

        case (item.command)
            i2cms_pkg::CMD_LOAD_BYTE: begin
                // loads only while idle so a running transfer keeps its data
                if (phase_reg == PH_READY && slot_ok) begin
                    buf_req.we = 1'b1;
                end
            end
            i2cms_pkg::CMD_START_XFER: begin
                if (item.transfer_length > i2cms_pkg::DEPTH_LEN) begin
                    result.transfer_done = 1'b1;
                    result.done_status   = i2cms_pkg::ST_TOO_LONG;
                    moved_zero           = 1'b1;
                end else if (phase_reg != PH_READY) begin
                    fault_code_next      = i2cms_pkg::ST_OTHER;
                    result.transfer_done = 1'b1;
                    result.done_status   = i2cms_pkg::ST_OTHER;
                    moved_zero           = 1'b1;
                end else begin
                    stop_at_end_next   = item.end_with_stop;
                    fault_code_next    = i2cms_pkg::ST_OK;
                    byte_index_next    = 6'd0;
                    byte_count_next    = item.transfer_length[5:0];
                    addr_phase_next    = 1'b1;
                    result.bus_tx_byte = {item.target_address, item.read_not_write};
                    // after a repeated start the core already holds the bus
                    if (rs_pending_reg) begin
                        rs_pending_next    = 1'b0;
                        result.bus_command = i2cms_pkg::BUS_WRITE;
                    end else begin
                        result.bus_command = i2cms_pkg::BUS_START_WRITE;
                    end
                    phase_next = item.read_not_write ? PH_READ : PH_WRITE;
                end
            end
            i2cms_pkg::CMD_BUS_EVENT: begin
                if (phase_reg != PH_READY) begin
                    if (item.arbitration_lost) begin
                        // release the bus without a command
                        fault_code_next      = i2cms_pkg::ST_OTHER;
                        phase_next           = PH_READY;
                        result.transfer_done = 1'b1;
                        result.done_status   = i2cms_pkg::ST_OTHER;
                    end else if (item.ack_missing) begin
                        if (phase_reg == PH_WRITE) begin
                            fault_code_next = (byte_index_reg == 6'd0) ?
                                              i2cms_pkg::ST_ADDR_NACK :
                                              i2cms_pkg::ST_DATA_NACK;
                        end
                        result.bus_command   = i2cms_pkg::BUS_STOP;
                        phase_next           = PH_READY;
                        result.transfer_done = 1'b1;
                        result.done_status   = fault_code_next;
                    end else begin
                        // ack: next data byte or end of transfer
                        if (phase_reg == PH_WRITE) begin
                            addr_phase_next = 1'b0;
                            if (byte_index_reg < byte_count_reg &&
                                byte_index_reg < i2cms_pkg::DEPTH_IDX) begin
                                result.bus_tx_byte = buf_rdata;
                                byte_index_next    = byte_index_reg + 6'd1;
                                result.bus_command = i2cms_pkg::BUS_WRITE;
                            end
                        end else begin
                            if (addr_phase_reg) begin
                                addr_phase_next = 1'b0;
                            end else if (byte_index_reg < i2cms_pkg::DEPTH_IDX) begin
                                buf_req.we      = 1'b1;
                                buf_req.waddr   = byte_index_reg[i2cms_pkg::BUF_AW-1:0];
                                buf_req.wdata   = item.received_byte;
                                byte_index_next = byte_index_reg + 6'd1;
                            end
                            if (byte_index_next < byte_count_reg) begin
                                result.bus_command = i2cms_pkg::BUS_READ;
                            end
                        end
                        // transfer complete: stop or repeated start
                        if (result.bus_command == i2cms_pkg::BUS_NONE) begin
                            if (stop_at_end_reg) begin
                                result.bus_command = i2cms_pkg::BUS_STOP;
                            end else begin
                                result.bus_command = i2cms_pkg::BUS_START;
                                rs_pending_next    = 1'b1;
                            end
                            phase_next           = PH_READY;
                            result.transfer_done = 1'b1;
                            result.done_status   = fault_code_reg;
                        end
                    end
                end
            end
            i2cms_pkg::CMD_READ_BYTE: begin
                if (slot_ok) begin
                    result.buffer_byte = buf_rdata;
                end
            end
            default: begin
            end
        endcase

        result.bytes_moved = moved_zero ? 6'd0 : byte_index_next;
        result.busy_res    = (phase_next != PH_READY);
    end

    // transfer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_READY;
            stop_at_end_reg <= 1'b1;
            rs_pending_reg  <= 1'b0;
            addr_phase_reg  <= 1'b0;
            byte_index_reg  <= 6'd0;
            byte_count_reg  <= 6'd0;
            fault_code_reg  <= i2cms_pkg::ST_OK;
        end else if (en) begin
            phase_reg       <= phase_next;
            stop_at_end_reg <= stop_at_end_next;
            rs_pending_reg  <= rs_pending_next;
            addr_phase_reg  <= addr_phase_next;
            byte_index_reg  <= byte_index_next;
            byte_count_reg  <= byte_count_next;
            fault_code_reg  <= fault_code_next;
        end
    end

    // a repeated start is only pending between transfers
    `I2CMS_ASSERT(a_rs_idle, aclk, aresetn, !rs_pending_reg || phase_reg == PH_READY)
    // the byte index never runs past the programmed length
    `I2CMS_ASSERT(a_idx_bound, aclk, aresetn, byte_index_reg <= byte_count_reg)
    // a rejected over-long start leaves the phase alone
    `I2CMS_ASSERT_NEXT(a_long_keeps, aclk, aresetn,
        en && result.done_status == i2cms_pkg::ST_TOO_LONG,
        phase_reg == $past(phase_reg))

endmodule

FILE: design/i2c_master_transaction_sequencer.sv
// path: an accepted item is held in the input register, then moves through the controller into the result register
// throughput: one item per cycle while the result side takes items
// rate is set by the single pass through the controller between input and result registers
// reset: aresetn low clears both valid flags and the transfer state; buffer is not cleared
// ----------------------------------------------------------------------------
// i2c master transaction sequencer
// sequences i2c master read and write transfers above a byte-level bus core
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // buffer_slot, byte_value, target_address, read_not_write, transfer_length,
    // end_with_stop, arbitration_lost, ack_missing, received_byte
    input  logic [39:0] s_tdata,
    // command
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bus_tx_byte, transfer_done, done_status, bytes_moved, buffer_byte,
    // busy_res, zero padding
    output logic [31:0] m_tdata,
    // bus_command
    output logic [2:0]  m_tuser
);

    logic                 in_valid_reg;
    i2cms_pkg::in_item_t  in_item_reg, in_item_next;
    logic                 out_valid_reg;
    i2cms_pkg::out_item_t out_item_reg;
    i2cms_pkg::out_item_t result;
    i2cms_pkg::buf_req_t  buf_req;
    logic [7:0]           buf_rdata;
    logic                 advance;

    // unpack the input item
    always_comb begin
        in_item_next.command          = i2cms_pkg::item_cmd_t'(s_tuser);
        in_item_next.buffer_slot      = s_tdata[4:0];
        in_item_next.byte_value       = s_tdata[12:5];
        in_item_next.target_address   = s_tdata[19:13];
        in_item_next.read_not_write   = s_tdata[20];
        in_item_next.transfer_length  = s_tdata[28:21];
        in_item_next.end_with_stop    = s_tdata[29];
        in_item_next.arbitration_lost = s_tdata[30];
        in_item_next.ack_missing      = s_tdata[31];
        in_item_next.received_byte    = s_tdata[39:32];
    end

    // pipeline flow control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_next;
        end
    end

    i2cms_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .item      (in_item_reg),
        .buf_rdata (buf_rdata),
        .buf_req   (buf_req),
        .result    (result)
    );

    i2cms_buffer u_buffer (
        .aclk  (aclk),
        .req   ('{we: buf_req.we && advance, waddr: buf_req.waddr,
                  wdata: buf_req.wdata, raddr: buf_req.raddr}),
        .rdata (buf_rdata)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result;
        end
    end

    // pack the result item
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_item_reg.bus_command;
    assign m_tdata  = {5'd0,
                       out_item_reg.busy_res,
                       out_item_reg.buffer_byte,
                       out_item_reg.bytes_moved,
                       out_item_reg.done_status,
                       out_item_reg.transfer_done,
                       out_item_reg.bus_tx_byte};

endmodule
